// ----- rtl/rotate_vector_axis_angle_defines.svh -----
`ifndef ROTATE_VECTOR_AXIS_ANGLE_DEFINES_SVH
`define ROTATE_VECTOR_AXIS_ANGLE_DEFINES_SVH

// check that c holds in the same cycle as a, outside reset
`define RVA_ASSERT_SAME(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("rva check failed");

// check that c holds in the cycle after a, outside reset
`define RVA_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("rva check failed");

// check that c holds in the cycle after a, reset included
`define RVA_ASSERT_ALWAYS(lbl, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("rva check failed");

`endif

// ----- rtl/rva_pkg.sv -----
`default_nettype none
package rva_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int NUM_STAGES   = CORDIC_STEPS + 3;
  localparam int LAST_STAGE   = NUM_STAGES - 1;
  localparam int TRIG_FRAC    = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [26:0] ONE_TRIG    = 27'sd16777216;
  localparam logic signed [63:0] SAT_MAX     = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN     = -64'sd2147483648;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  typedef struct packed {
    logic [2:0][31:0] v;
    logic [2:0][15:0] k;
    logic [8:0][47:0] p;
    logic [2:0][33:0] w;
    logic [34:0]      d;
    logic [2:0][50:0] kd;
    logic [2:0][35:0] ax;
  } side_t;

  function automatic logic signed [32:0] atan_turns(input int unsigned i);
    logic signed [32:0] r;
    r = '0;
    case (i)
      0:  r = 33'sh020000000;
      1:  r = 33'sh012E4051E;
      2:  r = 33'sh009FB385B;
      3:  r = 33'sh0051111D4;
      4:  r = 33'sh0028B0D43;
      5:  r = 33'sh00145D7E1;
      6:  r = 33'sh000A2F61E;
      7:  r = 33'sh000517C55;
      8:  r = 33'sh00028BE53;
      9:  r = 33'sh000145F2F;
      10: r = 33'sh0000A2F98;
      11: r = 33'sh0000517CC;
      12: r = 33'sh000028BE6;
      13: r = 33'sh0000145F3;
      14: r = 33'sh00000A2FA;
      15: r = 33'sh00000517D;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] rnd64(input logic signed [63:0] a,
                                               input int unsigned sh);
    logic signed [63:0] half;
    half = 64'sd1 <<< (sh - 1);
    return (a + half) >>> sh;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rva_if.sv -----
`default_nettype none
interface rva_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic [15:0]        turn_angle;
  modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle,
                  input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle,
                output ready);
endinterface

interface rva_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               overflowed;
  modport source (output valid, out_x, out_y, out_z, overflowed, input ready);
  modport sink (input valid, out_x, out_y, out_z, overflowed, output ready);
endinterface
`default_nettype wire

// ----- rtl/rotate_vector_axis_angle.sv -----
// channel | dir | payload
// req     | in  | vec_x/y/z Q16.16, axis_x/y/z Q1.15, turn_angle
// rsp     | out | out_x/y/z Q16.16 saturated, overflowed
// One request per cycle while the output is not held, through a 19-stage pipeline
// (16 CORDIC stages plus trig mapping, products and sum/saturate).
// The whole pipeline advances when the output register is empty or taken.
// rst is synchronous and clears all valid bits.
`default_nettype none
module rotate_vector_axis_angle (
  input  wire logic clk,
  input  wire logic rst,
  rva_in_if.sink    req,
  rva_out_if.source rsp
);
  import rva_pkg::*;

  logic                     en;
  logic [NUM_STAGES-1:0]    vld;
  logic signed [33:0]       cx [CORDIC_STEPS];
  logic signed [33:0]       cy [CORDIC_STEPS];
  logic signed [32:0]       cz [CORDIC_STEPS];
  logic [1:0]               cq [CORDIC_STEPS];
  side_t                    side [CORDIC_STEPS];
  logic signed [25:0]       tc;
  logic signed [25:0]       ts;
  logic signed [26:0]       omc;
  side_t                    tside;
  logic [2:0][63:0]         m_vc;
  logic [2:0][63:0]         m_ws;
  logic [2:0][63:0]         m_ao;
  logic [2:0][31:0]         res;
  logic                     ovf;
  logic [2:0][31:0]         res_next;
  logic [2:0]               ovf_next;

  assign en        = !vld[LAST_STAGE] || rsp.ready;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STAGES-2:0], req.valid};
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [33:0] px;
    logic signed [33:0] py;
    logic signed [32:0] pz;
    logic [1:0]         pq;
    side_t              ps;
    side_t              ns;

    if (i == 0) begin : g_first
      assign px = CORDIC_GAIN;
      assign py = '0;
      assign pz = $signed({3'b000, req.turn_angle[13:0], 16'h0000});
      assign pq = req.turn_angle[15:14];
      always_comb begin
        ns = '0;
        ns.v[0] = req.vec_x;
        ns.v[1] = req.vec_y;
        ns.v[2] = req.vec_z;
        ns.k[0] = req.axis_x;
        ns.k[1] = req.axis_y;
        ns.k[2] = req.axis_z;
        ns.p[0] = 48'(req.axis_y * req.vec_z);
        ns.p[1] = 48'(req.axis_z * req.vec_y);
        ns.p[2] = 48'(req.axis_z * req.vec_x);
        ns.p[3] = 48'(req.axis_x * req.vec_z);
        ns.p[4] = 48'(req.axis_x * req.vec_y);
        ns.p[5] = 48'(req.axis_y * req.vec_x);
        ns.p[6] = 48'(req.axis_x * req.vec_x);
        ns.p[7] = 48'(req.axis_y * req.vec_y);
        ns.p[8] = 48'(req.axis_z * req.vec_z);
      end
      assign ps = '0;
    end else begin : g_rest
      assign px = cx[i-1];
      assign py = cy[i-1];
      assign pz = cz[i-1];
      assign pq = cq[i-1];
      assign ps = side[i-1];
      if (i == 1) begin : g_cross
        always_comb begin
          ns = ps;
          ns.w[0] = 34'(rnd64(64'($signed(ps.p[0])) - 64'($signed(ps.p[1])), 15));
          ns.w[1] = 34'(rnd64(64'($signed(ps.p[2])) - 64'($signed(ps.p[3])), 15));
          ns.w[2] = 34'(rnd64(64'($signed(ps.p[4])) - 64'($signed(ps.p[5])), 15));
          ns.d    = 35'(rnd64(64'($signed(ps.p[6])) + 64'($signed(ps.p[7]))
                              + 64'($signed(ps.p[8])), 15));
        end
      end else if (i == 2) begin : g_kd
        always_comb begin
          ns = ps;
          for (int j = 0; j < 3; j++) begin
            ns.kd[j] = 51'($signed(ps.k[j]) * $signed(ps.d));
          end
        end
      end else if (i == 3) begin : g_axial
        always_comb begin
          ns = ps;
          for (int j = 0; j < 3; j++) begin
            ns.ax[j] = 36'(rnd64(64'($signed(ps.kd[j])), 15));
          end
        end
      end else begin : g_hold
        assign ns = ps;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (pz >= 0) begin
          cx[i] <= px - (py >>> i);
          cy[i] <= py + (px >>> i);
          cz[i] <= pz - atan_turns(i);
        end else begin
          cx[i] <= px + (py >>> i);
          cy[i] <= py - (px >>> i);
          cz[i] <= pz + atan_turns(i);
        end
        cq[i]   <= pq;
        side[i] <= ns;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [25:0] cr;
    logic signed [25:0] sr;
    logic signed [25:0] c;
    logic signed [25:0] s;
    cr = 26'(rnd64(64'(cx[CORDIC_STEPS-1]), 30 - TRIG_FRAC));
    sr = 26'(rnd64(64'(cy[CORDIC_STEPS-1]), 30 - TRIG_FRAC));
    case (cq[CORDIC_STEPS-1])
      QUAD_0: begin
        c = cr;
        s = sr;
      end
      QUAD_1: begin
        c = -sr;
        s = cr;
      end
      QUAD_2: begin
        c = -cr;
        s = -sr;
      end
      default: begin
        c = sr;
        s = -cr;
      end
    endcase
    if (en) begin
      tc    <= c;
      ts    <= s;
      omc   <= ONE_TRIG - 27'(c);
      tside <= side[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        m_vc[j] <= 64'($signed(tside.v[j]) * tc);
        m_ws[j] <= 64'($signed(tside.w[j]) * ts);
        m_ao[j] <= 64'($signed(tside.ax[j]) * omc);
      end
    end
  end

  always_comb begin
    logic signed [63:0] r;
    for (int j = 0; j < 3; j++) begin
      r = rnd64($signed(m_vc[j]) + $signed(m_ws[j]) + $signed(m_ao[j]), TRIG_FRAC);
      if (r > SAT_MAX) begin
        res_next[j] = 32'h7FFFFFFF;
        ovf_next[j] = 1'b1;
      end else if (r < SAT_MIN) begin
        res_next[j] = 32'h80000000;
        ovf_next[j] = 1'b1;
      end else begin
        res_next[j] = r[31:0];
        ovf_next[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
      ovf <= |ovf_next;
    end
  end

  assign rsp.valid      = vld[LAST_STAGE];
  assign rsp.out_x      = res[0];
  assign rsp.out_y      = res[1];
  assign rsp.out_z      = res[2];
  assign rsp.overflowed = ovf;

endmodule
`default_nettype wire

// ----- rtl/rva_checker.sv -----
`default_nettype none
`include "rotate_vector_axis_angle_defines.svh"
module rva_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_x,
  input wire logic        overflowed
);
  `RVA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `RVA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_x) && $stable(overflowed))
  `RVA_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid)
  `RVA_ASSERT_SAME(a_ready_free, !out_valid || out_ready, in_ready)
endmodule

bind rotate_vector_axis_angle rva_checker u_rva_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_x      (rsp.out_x),
  .overflowed (rsp.overflowed)
);
`default_nettype wire
